// ===== src/srv_pkg.sv =====
`default_nettype none

package srv_pkg;

  // Frame geometry and sensor storage.
  localparam int unsigned SensorCount = 2;
  localparam int unsigned FrameBytes  = 9;
  localparam int unsigned PosW        = $clog2(FrameBytes + 1);

  // Payload and register widths.
  localparam int unsigned ReadingW = 16;
  localparam int unsigned LimitW   = 12;
  localparam int unsigned SettleW  = 7;
  localparam int unsigned ErrW     = 16;
  localparam int unsigned VerdictW = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Raw reading patterns and limits.
  localparam logic [ReadingW-1:0] Sentinel       = 16'hFC90;
  localparam logic [ReadingW-1:0] PatternAllOnes = 16'hFFFF;
  localparam logic [ReadingW-1:0] PatternPowerOn = 16'h0550;
  localparam logic [ReadingW-1:0] RangeLowEdge   = 16'h07D0;
  localparam logic [SettleW-1:0]  SettleCap      = 7'd100;
  localparam logic [7:0]          CrcPoly        = 8'h8C;

  // Register reset values.
  localparam logic                NarrowRstWide   = 1'b0;
  localparam logic [LimitW-1:0]   NarrowLimitRst  = 12'd20;
  localparam logic [LimitW-1:0]   WideLimitRst    = 12'd30;
  localparam logic [SettleW-1:0]  SettleReadsRst  = 7'd29;
  localparam logic [ErrW-1:0]     ErrorLimitRst   = 16'h02FF;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgWideMode    = 3'd0,
    CfgNarrowLimit = 3'd1,
    CfgWideLimit   = 3'd2,
    CfgSettleReads = 3'd3,
    CfgErrorLimit  = 3'd4
  } cfg_idx_e;

  // Frame verdict codes.
  typedef enum logic [VerdictW-1:0] {
    VerdictAccept  = 3'd0,
    VerdictDelta   = 3'd1,
    VerdictPattern = 3'd2,
    VerdictCrc     = 3'd3,
    VerdictRange   = 3'd4
  } verdict_e;

  // One byte of the Dallas CRC-8, reflected polynomial, LSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/srv_in_if.sv =====
`default_nettype none

interface srv_in_if;
  logic       valid;
  logic       ready;
  logic       sensor_select;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output sensor_select, output data_byte, output frame_start,
                  input ready);
  modport sink (input valid, input sensor_select, input data_byte, input frame_start,
                output ready);
endinterface

`default_nettype wire

// ===== src/srv_out_if.sv =====
`default_nettype none

interface srv_out_if;
  logic                          valid;
  logic                          ready;
  logic                          sensor_id;
  logic [srv_pkg::ReadingW-1:0]  held_value;
  logic [srv_pkg::VerdictW-1:0]  verdict;
  logic [srv_pkg::ErrW-1:0]      error_total;
  logic                          fault_event;
  logic                          fault_latched;

  modport source (output valid, output sensor_id, output held_value, output verdict,
                  output error_total, output fault_event, output fault_latched,
                  input ready);
  modport sink (input valid, input sensor_id, input held_value, input verdict,
                input error_total, input fault_event, input fault_latched,
                output ready);
endinterface

`default_nettype wire

// ===== src/sensor_reading_validator_top.sv =====
// Sensor reading validator.
// The input channel carries one scratchpad byte per beat, with the sensor it
// came from and a frame start mark on byte 0. Every byte runs through a Dallas
// CRC-8; bytes 0 and 1 form the raw reading, low byte first. The last byte of a
// frame (the CRC byte) produces exactly one result beat on the output channel
// with the verdict, the stored reading, the shared error count and fault flags.
// All other bytes produce no result beat.
// A byte taken into the input register is judged there; a final byte's result
// beat is loaded into the result register when that byte advances. Throughput
// is one byte per cycle while no final byte waits on a stalled receiver, set by
// the single processing stage between the input and result registers.
// When the receiver stalls, the result register holds its beat; the input
// register keeps taking non-final bytes, and a final byte waits in the input
// register until the result register frees up, which then backs up the input.
// Reset clears the CRC, byte position, counters and fault flag, sets both
// stored readings to the sentinel and restores the register defaults.
// Configuration writes are taken whenever cfg_we_i is high; write them only
// while no frame is in flight.
`default_nettype none

module sensor_reading_validator_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [srv_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [srv_pkg::CfgDataW-1:0]    cfg_data_i,
  srv_in_if.sink                         in_i,
  srv_out_if.source                      out_o
);

  localparam logic [srv_pkg::PosW-1:0] LastPos  = srv_pkg::PosW'(srv_pkg::FrameBytes - 1);
  localparam logic [srv_pkg::PosW-1:0] FrameEnd = srv_pkg::PosW'(srv_pkg::FrameBytes);

  // Configuration registers.
  logic                         wide_mode_q;
  logic [srv_pkg::LimitW-1:0]   narrow_limit_q;
  logic [srv_pkg::LimitW-1:0]   wide_limit_q;
  logic [srv_pkg::SettleW-1:0]  settle_reads_q;
  logic [srv_pkg::ErrW-1:0]     error_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q    <= srv_pkg::NarrowRstWide;
      narrow_limit_q <= srv_pkg::NarrowLimitRst;
      wide_limit_q   <= srv_pkg::WideLimitRst;
      settle_reads_q <= srv_pkg::SettleReadsRst;
      error_limit_q  <= srv_pkg::ErrorLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srv_pkg::CfgWideMode:    wide_mode_q    <= cfg_data_i[0];
        srv_pkg::CfgNarrowLimit: narrow_limit_q <= cfg_data_i[srv_pkg::LimitW-1:0];
        srv_pkg::CfgWideLimit:   wide_limit_q   <= cfg_data_i[srv_pkg::LimitW-1:0];
        srv_pkg::CfgSettleReads: settle_reads_q <= cfg_data_i[srv_pkg::SettleW-1:0];
        srv_pkg::CfgErrorLimit:  error_limit_q  <= cfg_data_i[srv_pkg::ErrW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic       in_valid_q;
  logic       sel_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       advance;

  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      sel_q   <= in_i.sensor_select;
      byte_q  <= in_i.data_byte;
      start_q <= in_i.frame_start;
    end
  end

  // Frame and judgement state.
  logic [7:0]                    crc_q;
  logic [srv_pkg::PosW-1:0]      pos_q;
  logic [7:0]                    low_q;
  logic [7:0]                    high_q;
  logic [srv_pkg::ReadingW-1:0]  stored_q [srv_pkg::SensorCount];
  logic [srv_pkg::SettleW-1:0]   settle_q;
  logic [srv_pkg::ErrW-1:0]      err_q;
  logic                          fault_q;

  // Result register.
  logic                          out_valid_q;
  logic                          res_sensor_q;
  logic [srv_pkg::ReadingW-1:0]  res_held_q;
  srv_pkg::verdict_e             res_verdict_q;
  logic [srv_pkg::ErrW-1:0]      res_err_q;
  logic                          res_event_q;
  logic                          res_fault_q;

  // Processing of the byte in the input register.
  logic [srv_pkg::PosW-1:0]      pos_eff;
  logic [7:0]                    crc_base;
  logic                          active;
  logic                          is_last;
  logic [7:0]                    crc_d;
  logic [srv_pkg::PosW-1:0]      pos_d;
  logic [7:0]                    low_d;
  logic [7:0]                    high_d;
  logic [srv_pkg::ReadingW-1:0]  raw;
  logic [srv_pkg::ReadingW-1:0]  held;
  logic [srv_pkg::ReadingW-1:0]  delta;
  logic [srv_pkg::ReadingW-1:0]  lim;
  logic [srv_pkg::SettleW-1:0]   settle_inc;
  logic [srv_pkg::ReadingW-1:0]  held_d;
  logic [srv_pkg::SettleW-1:0]   settle_mid;
  logic [srv_pkg::ErrW-1:0]      err_mid;
  srv_pkg::verdict_e             verdict;
  logic                          fault_hit;
  logic [srv_pkg::SettleW-1:0]   settle_d;
  logic [srv_pkg::ErrW-1:0]      err_d;
  logic                          fault_d;

  always_comb begin
    // A frame start restarts the CRC and the byte count before this byte.
    pos_eff  = start_q ? '0 : pos_q;
    crc_base = start_q ? '0 : crc_q;
    active   = pos_eff < FrameEnd;
    is_last  = active && (pos_eff == LastPos);
    crc_d    = srv_pkg::crc8_update(crc_base, byte_q);
    pos_d    = pos_eff + srv_pkg::PosW'(1);
    low_d    = (pos_eff == '0) ? byte_q : low_q;
    high_d   = (pos_eff == srv_pkg::PosW'(1)) ? byte_q : high_q;

    raw  = {high_d, low_d};
    // Two sensors and a one-bit select: the select is always in range.
    held = stored_q[sel_q];
    lim  = srv_pkg::ReadingW'(wide_mode_q ? wide_limit_q : narrow_limit_q);
    delta = (raw >= held) ? (raw - held) : (held - raw);
    settle_inc = (settle_q < srv_pkg::SettleCap) ? (settle_q + srv_pkg::SettleW'(1)) : settle_q;

    held_d     = held;
    settle_mid = settle_q;
    err_mid    = err_q;
    if (raw == srv_pkg::PatternAllOnes || raw == srv_pkg::PatternPowerOn) begin
      err_mid = err_q + srv_pkg::ErrW'(1);
      verdict = srv_pkg::VerdictPattern;
    end else if (crc_d != '0) begin
      verdict = srv_pkg::VerdictCrc;
    end else if (raw >= srv_pkg::RangeLowEdge && raw <= srv_pkg::Sentinel) begin
      verdict = srv_pkg::VerdictRange;
    end else begin
      settle_mid = settle_inc;
      if ((settle_inc > settle_reads_q && delta < lim) || held == srv_pkg::Sentinel) begin
        held_d  = raw;
        err_mid = '0;
        verdict = srv_pkg::VerdictAccept;
      end else begin
        err_mid = err_q + srv_pkg::ErrW'(1);
        verdict = srv_pkg::VerdictDelta;
      end
    end

    // The limit compare follows every judgement, whatever the verdict.
    fault_hit = (err_mid == error_limit_q);
    err_d     = fault_hit ? '0 : err_mid;
    settle_d  = fault_hit ? '0 : settle_mid;
    fault_d   = fault_q || fault_hit;
  end

  // A final byte needs room in the result register; other bytes never wait.
  assign advance = in_valid_q && (!is_last || !out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= '0;
      pos_q    <= '0;
      low_q    <= '0;
      high_q   <= '0;
      settle_q <= '0;
      err_q    <= '0;
      fault_q  <= 1'b0;
      for (int i = 0; i < srv_pkg::SensorCount; i++) begin
        stored_q[i] <= srv_pkg::Sentinel;
      end
    end else if (advance && active) begin
      crc_q  <= crc_d;
      pos_q  <= pos_d;
      low_q  <= low_d;
      high_q <= high_d;
      if (is_last) begin
        stored_q[sel_q] <= held_d;
        settle_q        <= settle_d;
        err_q           <= err_d;
        fault_q         <= fault_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_last) begin
      res_sensor_q  <= sel_q;
      res_held_q    <= held_d;
      res_verdict_q <= verdict;
      res_err_q     <= err_d;
      res_event_q   <= fault_hit;
      res_fault_q   <= fault_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sensor_id     = res_sensor_q;
  assign out_o.held_value    = res_held_q;
  assign out_o.verdict       = res_verdict_q;
  assign out_o.error_total   = res_err_q;
  assign out_o.fault_event   = res_event_q;
  assign out_o.fault_latched = res_fault_q;

  // Once set, the sensor fault stays set until reset.
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q)
    else $error("sticky fault cleared");

  // A fault event always shows the latched flag and a cleared counter.
  a_event_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_event_q) |-> (res_fault_q && res_err_q == '0))
    else $error("fault event without latch or counter clear");

  // An accepted reading leaves the error counter at zero.
  a_accept_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_verdict_q == srv_pkg::VerdictAccept) |-> (res_err_q == '0))
    else $error("accepted frame with nonzero error count");

  // A final byte held back by a stalled receiver stays in the input register.
  a_final_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(byte_q) && $stable(sel_q)))
    else $error("stalled final byte lost");

  // A pending result beat stays unchanged until the receiver takes it.
  a_result_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(res_held_q)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
